/* rtl/core/rsm_pkg.sv */
// ----------------------------------------------------------------------------
// rsm_pkg
// Shared types, constants and the restoring divider step for the sector mapper.
// ----------------------------------------------------------------------------
package rsm_pkg;

  localparam int unsigned SECTOR_BITS = 32;
  localparam int unsigned DIV_STAGES  = SECTOR_BITS;
  localparam int unsigned DIVISOR_W   = 17;
  localparam int unsigned DISK_W      = 6;
  localparam int unsigned LEVEL_W     = 3;
  localparam int unsigned COUNT_W     = 7;
  localparam int unsigned CFG_IDX_W   = 2;

  localparam logic [COUNT_W-1:0]   DISKS_MIN = 7'd2;
  localparam logic [COUNT_W-1:0]   DISKS_MAX = 7'd64;
  localparam logic [DIVISOR_W-1:0] CHUNK_MAX = 17'd65536;

  localparam logic [LEVEL_W-1:0] LVL_RAID0  = 3'd0;
  localparam logic [LEVEL_W-1:0] LVL_RAID1  = 3'd1;
  localparam logic [LEVEL_W-1:0] LVL_RAID01 = 3'd2;
  localparam logic [LEVEL_W-1:0] LVL_RAID10 = 3'd3;
  localparam logic [LEVEL_W-1:0] LVL_RAID4  = 3'd4;
  localparam logic [LEVEL_W-1:0] LVL_RAID5  = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DISKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK = 2'd2;

  typedef struct packed {
    logic [DIVISOR_W-1:0]   rem;
    logic [SECTOR_BITS-1:0] num;
  } div_t;

  function automatic div_t div_step(input logic [DIVISOR_W-1:0]   rem,
                                    input logic [SECTOR_BITS-1:0] num,
                                    input logic [DIVISOR_W-1:0]   d);
    logic [DIVISOR_W:0] trial;
    div_t               r;
    trial = {rem, num[SECTOR_BITS-1]};
    if (trial >= {1'b0, d}) begin
      r.rem = DIVISOR_W'(trial - {1'b0, d});
      r.num = {num[SECTOR_BITS-2:0], 1'b1};
    end else begin
      r.rem = trial[DIVISOR_W-1:0];
      r.num = {num[SECTOR_BITS-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

/* rtl/core/raid_sector_mapper_core.sv */
// ----------------------------------------------------------------------------
// raid_sector_mapper_core
// Maps a logical sector to data disk, on-disk block and mirror/parity disk.
// Throughput: one transaction per cycle; busy is held low, the receiver
// cannot stall. Built from two 32-stage restoring divider banks in series.
// Reset clears the valid pipeline and loads RAID0, two disks, chunk of one.
// Levels 6 and 7 produce no result.
// ----------------------------------------------------------------------------
module raid_sector_mapper_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [rsm_pkg::SECTOR_BITS-1:0]   sector_i,
  input  logic                              cfg_we_i,
  input  logic [rsm_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [rsm_pkg::DIVISOR_W-1:0]     cfg_data_i,
  output logic                              result_valid_o,
  output logic [rsm_pkg::DISK_W-1:0]        data_disk_o,
  output logic [rsm_pkg::SECTOR_BITS-1:0]   disk_block_o,
  output logic [rsm_pkg::DISK_W-1:0]        second_disk_o,
  output logic                              has_second_o
);
  import rsm_pkg::*;

  logic [LEVEL_W-1:0]   raid_level_q;
  logic [COUNT_W-1:0]   disk_count_q;
  logic [DIVISOR_W-1:0] chunk_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raid_level_q <= LVL_RAID0;
      disk_count_q <= DISKS_MIN;
      chunk_q      <= DIVISOR_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LEVEL: raid_level_q <= cfg_data_i[LEVEL_W-1:0];
        CFG_DISKS: disk_count_q <= cfg_data_i[COUNT_W-1:0];
        CFG_CHUNK: chunk_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [COUNT_W-1:0]   n_eff;
  logic [DIVISOR_W-1:0] c_eff;
  logic [DIVISOR_W-1:0] d_a;
  logic [DIVISOR_W-1:0] d_n;
  logic [DISK_W-1:0]    half;
  logic                 level_ok;

  always_comb begin
    if (disk_count_q < DISKS_MIN)      n_eff = DISKS_MIN;
    else if (disk_count_q > DISKS_MAX) n_eff = DISKS_MAX;
    else                               n_eff = disk_count_q;
    if (chunk_q == '0)             c_eff = DIVISOR_W'(1);
    else if (chunk_q > CHUNK_MAX)  c_eff = CHUNK_MAX;
    else                           c_eff = chunk_q;
    half = DISK_W'(n_eff >> 1);
    d_n  = DIVISOR_W'(n_eff);
    case (raid_level_q)
      LVL_RAID0:              d_a = c_eff;
      LVL_RAID01, LVL_RAID10: d_a = DIVISOR_W'(half);
      LVL_RAID4, LVL_RAID5:   d_a = DIVISOR_W'(n_eff - COUNT_W'(1));
      default:                d_a = DIVISOR_W'(1);
    endcase
    level_ok = (raid_level_q <= LVL_RAID5);
  end

  assign busy = 1'b0;

  logic                   ab_v_q   [0:DIV_STAGES];
  logic [DIVISOR_W-1:0]   a_rem_q  [0:DIV_STAGES];
  logic [SECTOR_BITS-1:0] a_num_q  [0:DIV_STAGES];
  logic [DIVISOR_W-1:0]   b_rem_q  [0:DIV_STAGES];
  logic [SECTOR_BITS-1:0] b_num_q  [0:DIV_STAGES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ab_v_q[0] <= 1'b0;
    else         ab_v_q[0] <= start && !busy && level_ok;
  end

  always_ff @(posedge clk_i) begin
    a_rem_q[0] <= '0;
    a_num_q[0] <= sector_i;
    b_rem_q[0] <= '0;
    b_num_q[0] <= sector_i;
  end

  genvar k;
  for (k = 0; k < DIV_STAGES; k++) begin : g_ab
    div_t a_nx;
    div_t b_nx;
    assign a_nx = div_step(a_rem_q[k], a_num_q[k], d_a);
    assign b_nx = div_step(b_rem_q[k], b_num_q[k], d_n);
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) ab_v_q[k+1] <= 1'b0;
      else         ab_v_q[k+1] <= ab_v_q[k];
    end
    always_ff @(posedge clk_i) begin
      a_rem_q[k+1] <= a_nx.rem;
      a_num_q[k+1] <= a_nx.num;
      b_rem_q[k+1] <= b_nx.rem;
      b_num_q[k+1] <= b_nx.num;
    end
  end

  logic                   c_v_q   [0:DIV_STAGES];
  logic [DIVISOR_W-1:0]   c_rem_q [0:DIV_STAGES];
  logic [SECTOR_BITS-1:0] c_num_q [0:DIV_STAGES];
  logic [SECTOR_BITS-1:0] c_qa_q  [0:DIV_STAGES];
  logic [DIVISOR_W-1:0]   c_ra_q  [0:DIV_STAGES];
  logic [DISK_W-1:0]      c_rb_q  [0:DIV_STAGES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) c_v_q[0] <= 1'b0;
    else         c_v_q[0] <= ab_v_q[DIV_STAGES];
  end

  always_ff @(posedge clk_i) begin
    c_rem_q[0] <= '0;
    c_num_q[0] <= a_num_q[DIV_STAGES];
    c_qa_q[0]  <= a_num_q[DIV_STAGES];
    c_ra_q[0]  <= a_rem_q[DIV_STAGES];
    c_rb_q[0]  <= b_rem_q[DIV_STAGES][DISK_W-1:0];
  end

  for (k = 0; k < DIV_STAGES; k++) begin : g_c
    div_t c_nx;
    assign c_nx = div_step(c_rem_q[k], c_num_q[k], d_n);
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) c_v_q[k+1] <= 1'b0;
      else         c_v_q[k+1] <= c_v_q[k];
    end
    always_ff @(posedge clk_i) begin
      c_rem_q[k+1] <= c_nx.rem;
      c_num_q[k+1] <= c_nx.num;
      c_qa_q[k+1]  <= c_qa_q[k];
      c_ra_q[k+1]  <= c_ra_q[k];
      c_rb_q[k+1]  <= c_rb_q[k];
    end
  end

  logic [DIVISOR_W+SECTOR_BITS-1:0] prod_full;
  logic                             m_v_q;
  logic [SECTOR_BITS-1:0]           m_prod_q;
  logic [SECTOR_BITS-1:0]           m_qa_q;
  logic [DIVISOR_W-1:0]             m_ra_q;
  logic [DISK_W-1:0]                m_rb_q;
  logic [DISK_W-1:0]                m_rc_q;

  assign prod_full = c_eff * c_num_q[DIV_STAGES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m_v_q <= 1'b0;
    else         m_v_q <= c_v_q[DIV_STAGES];
  end

  always_ff @(posedge clk_i) begin
    m_prod_q <= prod_full[SECTOR_BITS-1:0];
    m_qa_q   <= c_qa_q[DIV_STAGES];
    m_ra_q   <= c_ra_q[DIV_STAGES];
    m_rb_q   <= c_rb_q[DIV_STAGES];
    m_rc_q   <= c_rem_q[DIV_STAGES][DISK_W-1:0];
  end

  logic [DISK_W-1:0]      disk_d;
  logic [SECTOR_BITS-1:0] block_d;
  logic [DISK_W-1:0]      second_d;
  logic                   has_d;
  logic [DISK_W-1:0]      ra_disk;
  logic [DISK_W-1:0]      n_last;

  always_comb begin
    ra_disk  = m_ra_q[DISK_W-1:0];
    n_last   = DISK_W'(n_eff - COUNT_W'(1));
    disk_d   = ra_disk;
    block_d  = m_qa_q;
    second_d = '0;
    has_d    = 1'b1;
    case (raid_level_q)
      LVL_RAID0: begin
        disk_d  = m_rc_q;
        block_d = SECTOR_BITS'(m_ra_q) + m_prod_q;
        has_d   = 1'b0;
      end
      LVL_RAID1: begin
        disk_d   = '0;
        second_d = DISK_W'(1);
      end
      LVL_RAID01: second_d = ra_disk + half;
      LVL_RAID10: begin
        disk_d   = DISK_W'({ra_disk, 1'b0});
        second_d = DISK_W'({ra_disk, 1'b1});
      end
      LVL_RAID4: second_d = n_last;
      LVL_RAID5: begin
        disk_d   = m_rb_q;
        second_d = n_last - m_rc_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) result_valid_o <= 1'b0;
    else         result_valid_o <= m_v_q;
  end

  always_ff @(posedge clk_i) begin
    data_disk_o   <= disk_d;
    disk_block_o  <= block_d;
    second_disk_o <= second_d;
    has_second_o  <= has_d;
  end

  a_level_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> raid_level_q <= LVL_RAID5)
    else $error("result for an unused level");

  a_has_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> has_second_o == (raid_level_q != LVL_RAID0))
    else $error("has_second does not match level");

  a_disk_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> COUNT_W'(data_disk_o) < n_eff)
    else $error("data disk beyond disk count");

  a_raid1_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && raid_level_q == LVL_RAID1) |->
      (data_disk_o == '0 && second_disk_o == DISK_W'(1)))
    else $error("mirror pair wrong");

endmodule
